@@ design/vsa_pkg.sv @@
package vsa_pkg;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_VDONE,
      ST_TMUL0,
      ST_TMUL1,
      ST_TDONE,
      ST_COMMIT,
      ST_FIN,
      ST_ADONE,
      ST_CMUL0,
      ST_CMUL1,
      ST_R2DONE,
      ST_CDONE,
      ST_OUT
   } state_type;

   localparam logic [1:0] REG_FORWARD    = 2'd0;
   localparam logic [1:0] REG_EXPIRY     = 2'd1;
   localparam logic [1:0] REG_DISCOUNT   = 2'd2;
   localparam logic [1:0] REG_CORRECTION = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NONPOS     = 2'd1;
   localparam logic [1:0] STATUS_NOT_ASCEND = 2'd2;

   localparam logic [31:0] FORWARD_RESET  = 32'd6553600;
   localparam logic [31:0] EXPIRY_RESET   = 32'd16777216;
   localparam logic [31:0] DISCOUNT_RESET = 32'd1073741824;

   localparam logic [46:0] FV_MAX     = {47{1'b1}};
   localparam logic [48:0] CORR_LIMIT = 49'h1_0000_0000_0000;
   localparam logic [49:0] FV_MIN     = {3'b111, 47'd0};

endpackage

@@ design/variance_strip_accumulator_unit.sv @@
// Variance strike from a strip of ascending option strikes, one request
// per strike, result on the request marked tlast. All products and quotients
// go through one 64-bit restoring divider (one quotient bit per cycle) and one
// 32x32 multiplier under a sequencer; the block is not ready while it works. A
// request divides once for the forward value and once per weight term it closes
// (none on a first strike that is not last, two on a last strike after the
// first, else one); the last request adds one finishing division, or three with
// the below-forward correction, before the result is offered. Configuration
// is always ready; the user writes it between strips, not enforced by the block.
module variance_strip_accumulator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // strike[31:0], otm_price[63:32]
   input  logic        req_tlast,   // last_in_strip
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // var_strike[47:0]
   output logic [2:0]  rsp_tuser,   // status[1:0], saturated[2]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import vsa_pkg::*;

   state_type   state_ff, state_in, ret_ff, ret_in;
   logic [31:0] fwd_ff, fwd_in, tte_ff, tte_in, disc_ff, disc_in;
   logic        corr_ff, corr_in;
   logic [31:0] k_ff, k_in, p_ff, p_in, v_ff, v_in;
   logic        last_ff, last_in;
   logic [31:0] earlier_ff, earlier_in, pend_ff, pend_in, pval_ff, pval_in;
   logic [1:0]  seen_ff, seen_in, err_ff, err_in;
   logic [63:0] sum_ff, sum_in;
   logic [31:0] k0_ff, k0_in;
   logic        ovf_ff, ovf_in;
   logic [31:0] tk_ff, tk_in, tdk_ff, tdk_in, tval_ff, tval_in;
   logic        tsh31_ff, tsh31_in, tcur_ff, tcur_in;
   logic [63:0] prod_ff, prod_in, den_ff, den_in, rem_ff, rem_in;
   logic [63:0] nlo_ff, nlo_in, quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        first_ff, first_in;
   logic [46:0] a_ff, a_in;
   logic [47:0] res_ff, res_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic [2:0]  rsp_user_ff, rsp_user_in;

   logic [31:0]  mul_x, mul_y, vsat, dabs;
   logic [63:0]  mul_p, shl, dif;
   logic         carry, ge;
   logic [127:0] tnum;
   logic [64:0]  sum_ext;
   logic [48:0]  cval;
   logic [49:0]  diff;
   logic [1:0]   echk;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign mul_p   = {32'd0, mul_x} * {32'd0, mul_y};
   assign carry   = rem_ff[63];
   assign shl     = {rem_ff[62:0], nlo_ff[63]};
   assign ge      = carry || (shl >= den_ff);
   assign dif     = shl - den_ff;
   assign tnum    = {64'd0, prod_ff} << (tsh31_ff ? 7'd31 : 7'd32);
   assign sum_ext = {1'b0, sum_ff} + {1'b0, quo_ff};
   assign dabs    = (fwd_ff >= k0_ff) ? (fwd_ff - k0_ff) : (k0_ff - fwd_ff);
   assign vsat    = (quo_ff[63:32] != 32'd0) ? 32'hFFFF_FFFF : quo_ff[31:0];
   assign cval    = (quo_ff > {15'd0, CORR_LIMIT}) ? CORR_LIMIT : quo_ff[48:0];
   assign diff    = {3'b000, a_ff} - {1'b0, cval};

   always_comb begin
      mul_x = tdk_ff;
      mul_y = tval_ff;
      unique case (state_ff)
         ST_TMUL1: begin
            mul_x = tk_ff;
            mul_y = tk_ff;
         end
         ST_CMUL0: begin
            mul_x = dabs;
            mul_y = dabs;
         end
         ST_CMUL1: begin
            mul_x = k0_ff;
            mul_y = k0_ff;
         end
         default: begin
            mul_x = tdk_ff;
            mul_y = tval_ff;
         end
      endcase
   end

   always_comb begin
      echk = err_ff;
      if (err_ff == STATUS_OK) begin
         if (k_ff == 32'd0) begin
            echk = STATUS_NONPOS;
         end else if (seen_ff != 2'd0 && k_ff <= pend_ff) begin
            echk = STATUS_NOT_ASCEND;
         end
      end
   end

   always_comb begin
      state_in = state_ff;   ret_in = ret_ff;
      fwd_in = fwd_ff;       tte_in = tte_ff;   disc_in = disc_ff;  corr_in = corr_ff;
      k_in = k_ff;           p_in = p_ff;       v_in = v_ff;        last_in = last_ff;
      earlier_in = earlier_ff; pend_in = pend_ff; pval_in = pval_ff;
      seen_in = seen_ff;     err_in = err_ff;   sum_in = sum_ff;    k0_in = k0_ff;
      ovf_in = ovf_ff;
      tk_in = tk_ff;  tdk_in = tdk_ff;  tval_in = tval_ff;
      tsh31_in = tsh31_ff;   tcur_in = tcur_ff;
      prod_in = prod_ff;  den_in = den_ff;  rem_in = rem_ff;  nlo_in = nlo_ff;
      quo_in = quo_ff;    cnt_in = cnt_ff;  first_in = first_ff;
      a_in = a_ff;        res_in = res_ff;
      rsp_valid_in = rsp_valid_ff;  rsp_data_in = rsp_data_ff;  rsp_user_in = rsp_user_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            REG_FORWARD:    fwd_in  = csr_data;
            REG_EXPIRY:     tte_in  = csr_data;
            REG_DISCOUNT:   disc_in = csr_data;
            REG_CORRECTION: corr_in = csr_data[0];
            default:        corr_in = corr_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               k_in     = req_tdata[31:0];
               p_in     = req_tdata[63:32];
               last_in  = req_tlast;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            err_in = echk;
            if (echk != STATUS_OK) begin
               state_in = last_ff ? ST_OUT : ST_IDLE;
            end else begin
               rem_in   = 64'd0;
               nlo_in   = {2'b00, p_ff, 30'd0};
               den_in   = {32'd0, disc_ff};
               first_in = 1'b1;
               ret_in   = ST_VDONE;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (first_ff) begin
               first_in = 1'b0;
               cnt_in   = 6'd0;
               quo_in   = 64'd0;
               if (den_ff == 64'd0 || rem_ff >= den_ff) begin
                  quo_in   = {64{1'b1}};
                  ovf_in   = 1'b1;
                  state_in = ret_ff;
               end
            end else begin
               nlo_in = {nlo_ff[62:0], 1'b0};
               rem_in = ge ? dif : shl;
               quo_in = {quo_ff[62:0], ge};
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd63) begin
                  state_in = ret_ff;
               end
            end
         end
         ST_VDONE: begin
            v_in = vsat;
            if (quo_ff[63:32] != 32'd0) begin
               ovf_in = 1'b1;
            end
            if (seen_ff != 2'd0) begin
               tk_in    = pend_ff;
               tdk_in   = (seen_ff == 2'd1) ? (k_ff - pend_ff) : (k_ff - earlier_ff);
               tsh31_in = (seen_ff != 2'd1);
               tval_in  = pval_ff;
               tcur_in  = 1'b0;
               state_in = ST_TMUL0;
            end else if (last_ff) begin
               tk_in    = k_ff;
               tdk_in   = k_ff;
               tsh31_in = 1'b0;
               tval_in  = vsat;
               tcur_in  = 1'b1;
               state_in = ST_TMUL0;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_TMUL0: begin
            prod_in  = mul_p;
            state_in = ST_TMUL1;
         end
         ST_TMUL1: begin
            den_in   = mul_p;
            rem_in   = tnum[127:64];
            nlo_in   = tnum[63:0];
            first_in = 1'b1;
            ret_in   = ST_TDONE;
            state_in = ST_DIV;
         end
         ST_TDONE: begin
            if (sum_ext[64]) begin
               sum_in = {64{1'b1}};
               ovf_in = 1'b1;
            end else begin
               sum_in = sum_ext[63:0];
            end
            if (!tcur_ff && last_ff) begin
               tk_in    = k_ff;
               tdk_in   = k_ff - pend_ff;
               tsh31_in = 1'b0;
               tval_in  = v_ff;
               tcur_in  = 1'b1;
               state_in = ST_TMUL0;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (k_ff < fwd_ff) begin
               k0_in = k_ff;
            end
            earlier_in = pend_ff;
            pend_in    = k_ff;
            pval_in    = v_ff;
            if (seen_ff != 2'd2) begin
               seen_in = seen_ff + 2'd1;
            end
            state_in = last_ff ? ST_FIN : ST_IDLE;
         end
         ST_FIN: begin
            rem_in   = {39'd0, sum_ff[63:39]};
            nlo_in   = {sum_ff[38:0], 25'd0};
            den_in   = {32'd0, tte_ff};
            first_in = 1'b1;
            ret_in   = ST_ADONE;
            state_in = ST_DIV;
         end
         ST_ADONE: begin
            if (quo_ff > {17'd0, FV_MAX}) begin
               a_in   = FV_MAX;
               ovf_in = 1'b1;
            end else begin
               a_in = quo_ff[46:0];
            end
            if (corr_ff && k0_ff != 32'd0) begin
               state_in = ST_CMUL0;
            end else begin
               res_in   = (quo_ff > {17'd0, FV_MAX}) ? {1'b0, FV_MAX} : {1'b0, quo_ff[46:0]};
               state_in = ST_OUT;
            end
         end
         ST_CMUL0: begin
            prod_in  = mul_p;
            state_in = ST_CMUL1;
         end
         ST_CMUL1: begin
            den_in   = mul_p;
            rem_in   = {32'd0, prod_ff[63:32]};
            nlo_in   = {prod_ff[31:0], 32'd0};
            first_in = 1'b1;
            ret_in   = ST_R2DONE;
            state_in = ST_DIV;
         end
         ST_R2DONE: begin
            rem_in   = {40'd0, quo_ff[63:40]};
            nlo_in   = {quo_ff[39:0], 24'd0};
            den_in   = {32'd0, tte_ff};
            first_in = 1'b1;
            ret_in   = ST_CDONE;
            state_in = ST_DIV;
         end
         ST_CDONE: begin
            if ($signed(diff) < $signed(FV_MIN)) begin
               res_in = FV_MIN[47:0];
               ovf_in = 1'b1;
            end else begin
               res_in = diff[47:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (err_ff != STATUS_OK) begin
                  rsp_data_in = 48'd0;
                  rsp_user_in = {1'b0, err_ff};
               end else begin
                  rsp_data_in = res_ff;
                  rsp_user_in = {ovf_ff, STATUS_OK};
               end
               earlier_in = 32'd0;
               pend_in    = 32'd0;
               pval_in    = 32'd0;
               seen_in    = 2'd0;
               sum_in     = 64'd0;
               k0_in      = 32'd0;
               err_in     = STATUS_OK;
               ovf_in     = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         fwd_ff       <= FORWARD_RESET;
         tte_ff       <= EXPIRY_RESET;
         disc_ff      <= DISCOUNT_RESET;
         corr_ff      <= 1'b1;
         earlier_ff   <= 32'd0;
         pend_ff      <= 32'd0;
         pval_ff      <= 32'd0;
         seen_ff      <= 2'd0;
         err_ff       <= STATUS_OK;
         sum_ff       <= 64'd0;
         k0_ff        <= 32'd0;
         ovf_ff       <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fwd_ff       <= fwd_in;
         tte_ff       <= tte_in;
         disc_ff      <= disc_in;
         corr_ff      <= corr_in;
         earlier_ff   <= earlier_in;
         pend_ff      <= pend_in;
         pval_ff      <= pval_in;
         seen_ff      <= seen_in;
         err_ff       <= err_in;
         sum_ff       <= sum_in;
         k0_ff        <= k0_in;
         ovf_ff       <= ovf_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      p_ff        <= p_in;
      v_ff        <= v_in;
      last_ff     <= last_in;
      tk_ff       <= tk_in;
      tdk_ff      <= tdk_in;
      tval_ff     <= tval_in;
      tsh31_ff    <= tsh31_in;
      tcur_ff     <= tcur_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      nlo_ff      <= nlo_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      a_ff        <= a_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

endmodule

@@ verif/tb_variance_strip_accumulator_unit.sv @@
`timescale 1ns / 100ps

module tb_variance_strip_accumulator_unit;
   import vsa_pkg::*;

   localparam int          CYCLE_LIMIT = 3000000;
   localparam int          SETTLE      = 600;
   localparam logic [63:0] A_MAX       = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] C_MAX       = 64'h0001_0000_0000_0000;
   localparam logic signed [63:0] RES_MIN = -64'sh0000_8000_0000_0000;

   typedef struct packed {
      logic [47:0] var_strike;
      logic [1:0]  status;
      logic        saturated;
   } variance_result_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   variance_result_t variance_q[$];
   int  error_count = 0;
   int  cycle_count = 0;
   int  burst_left  = 0;
   logic hold_rsp   = 1'b0;
   int  stall_phase = 0;
   bit  stall_mode  = 1'b0;

   // predictor copy of configuration and strip state
   logic [31:0] fwd_q, tte_q, disc_q;
   logic        corr_q;
   logic [31:0] earlier_k, held_k, held_v, k_below;
   int          n_seen;
   logic [63:0] w_sum;
   logic [1:0]  strip_err;
   bit          strip_ovf;

   variance_strip_accumulator_unit u_dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** variance_strip_accumulator_unit: FAILED **");
         $finish;
      end
   end

   function automatic logic [63:0] div_sat(input logic [63:0] nh, nl, den);
      logic [63:0] rem;
      logic [63:0] q;
      logic        carry;
      rem = nh;
      q = '0;
      if (den == 0 || nh >= den) begin
         strip_ovf = 1'b1;
         return '1;
      end
      for (int i = 63; i >= 0; i--) begin
         carry = rem[63];
         rem = {rem[62:0], nl[i]};
         q = q << 1;
         if (carry || rem >= den) begin
            rem = rem - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic void add_weight(input logic [31:0] k, input logic [63:0] dk,
                                      input int shift, input logic [31:0] v);
      logic [63:0] prod, den, t;
      logic [64:0] s;
      prod = dk * {32'd0, v};
      den = {32'd0, k} * {32'd0, k};
      t = div_sat(prod >> (64 - shift), prod << shift, den);
      s = {1'b0, w_sum} + {1'b0, t};
      if (s[64]) begin
         w_sum = '1;
         strip_ovf = 1'b1;
      end else begin
         w_sum = s[63:0];
      end
   endfunction

   function automatic void clear_strip();
      earlier_k = '0;
      held_k = '0;
      held_v = '0;
      n_seen = 0;
      w_sum = '0;
      k_below = '0;
      strip_err = STATUS_OK;
      strip_ovf = 1'b0;
   endfunction

   function automatic logic [47:0] finish_variance();
      logic [63:0] a, k0, d, d2, r2, c;
      logic signed [63:0] res;
      a = div_sat(w_sum >> 39, w_sum << 25, {32'd0, tte_q});
      if (a > A_MAX) begin
         a = A_MAX;
         strip_ovf = 1'b1;
      end
      res = a;
      if (corr_q && k_below != 0) begin
         k0 = {32'd0, k_below};
         d = {32'd0, fwd_q} - k0;
         d2 = d * d;
         r2 = div_sat(d2 >> 32, d2 << 32, k0 * k0);
         c = div_sat(r2 >> 40, r2 << 24, {32'd0, tte_q});
         if (c > C_MAX) c = C_MAX;
         res = res - $signed(c);
         if (res < RES_MIN) begin
            res = RES_MIN;
            strip_ovf = 1'b1;
         end
      end
      return res[47:0];
   endfunction

   function automatic void predict_strike(input logic [31:0] k, p, input logic last);
      logic [63:0] v64;
      variance_result_t r;
      if (strip_err == STATUS_OK) begin
         if (k == 0) strip_err = STATUS_NONPOS;
         else if (n_seen != 0 && k <= held_k) strip_err = STATUS_NOT_ASCEND;
      end
      if (strip_err == STATUS_OK) begin
         v64 = div_sat(64'd0, {32'd0, p} << 30, {32'd0, disc_q});
         if (v64 > 64'hFFFF_FFFF) begin
            v64 = 64'hFFFF_FFFF;
            strip_ovf = 1'b1;
         end
         if (n_seen == 1) add_weight(held_k, {32'd0, k - held_k}, 32, held_v);
         else if (n_seen >= 2) add_weight(held_k, {32'd0, k - earlier_k}, 31, held_v);
         if (k < fwd_q) k_below = k;
         if (last) begin
            if (n_seen == 0) add_weight(k, {32'd0, k}, 32, v64[31:0]);
            else add_weight(k, {32'd0, k - held_k}, 32, v64[31:0]);
         end
         earlier_k = held_k;
         held_k = k;
         held_v = v64[31:0];
         if (n_seen < 2) n_seen++;
      end
      if (!last) return;
      if (strip_err != STATUS_OK) begin
         r.var_strike = '0;
         r.status = strip_err;
         r.saturated = 1'b0;
      end else begin
         r.var_strike = finish_variance();
         r.status = STATUS_OK;
         r.saturated = strip_ovf;
      end
      variance_q = {variance_q, r};
      clear_strip();
   endfunction

   // result checker and receiver stall pattern
   always @(posedge clock) begin
      variance_result_t exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (variance_q.size() == 0) begin
            $error("unexpected result %h / %h", rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            exp_r = variance_q.pop_front();
            if (rsp_tdata !== exp_r.var_strike) begin
               $error("var_strike exp %h got %h", exp_r.var_strike, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[1:0] !== exp_r.status) begin
               $error("status exp %0d got %0d", exp_r.status, rsp_tuser[1:0]);
               error_count++;
            end
            if (rsp_tuser[2] !== exp_r.saturated) begin
               $error("saturated exp %0d got %0d", exp_r.saturated, rsp_tuser[2]);
               error_count++;
            end
         end
      end
      if (stall_phase == 0) begin
         stall_phase = $urandom_range(50, 400);
         stall_mode = $urandom_range(0, 1);
      end
      stall_phase--;
      if (hold_rsp) rsp_tready <= 1'b0;
      else if (stall_mode) rsp_tready <= ($urandom_range(0, 2) == 0);
      else rsp_tready <= 1'b1;
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_FORWARD:    fwd_q = val;
         REG_EXPIRY:     tte_q = val;
         REG_DISCOUNT:   disc_q = val;
         REG_CORRECTION: corr_q = val[0];
      endcase
   endtask

   task automatic configure(input logic [31:0] f, t, d, input logic [31:0] c);
      write_reg(REG_FORWARD, f);
      write_reg(REG_EXPIRY, t);
      write_reg(REG_DISCOUNT, d);
      write_reg(REG_CORRECTION, c);
      csr_valid <= 1'b0;
   endtask

   task automatic send_request(input logic [31:0] k, p, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 20);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {p, k};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predict_strike(k, p, last);
      burst_left--;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (variance_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_price();
      return $urandom >> $urandom_range(0, 31);
   endfunction

   // fault: 0 none, 1 zero strike, 2 repeated or lower strike
   task automatic send_strip(input int len, input int fault);
      logic [31:0] k;
      logic [31:0] prev;
      logic [32:0] nk;
      int          bad_at;
      bad_at = $urandom_range(0, len - 1);
      prev = '0;
      if ($urandom_range(0, 1)) k = (fwd_q >> $urandom_range(0, 4)) | 32'd1;
      else k = ($urandom >> $urandom_range(0, 31)) | 32'd1;
      for (int i = 0; i < len; i++) begin
         if (fault == 1 && i == bad_at) send_request(32'd0, rand_price(), i == len - 1);
         else if (fault == 2 && i == bad_at && i != 0)
            send_request(prev - $urandom_range(0, 1), rand_price(), i == len - 1);
         else send_request(k, rand_price(), i == len - 1);
         prev = k;
         nk = {1'b0, k} + ($urandom >> $urandom_range(6, 31)) + 33'd1;
         k = nk[32] ? k + 32'd1 : nk[31:0];
      end
   endtask

   task automatic test_directed();
      configure(FORWARD_RESET, EXPIRY_RESET, DISCOUNT_RESET, 32'd1);
      send_request(32'd6553600, 32'd65536, 1'b1);
      send_request(32'd5898240, 32'd200000, 1'b0);
      send_request(32'd6553600, 32'd300000, 1'b0);
      send_request(32'd7208960, 32'd150000, 1'b1);
      send_request(32'd1, 32'hFFFF_FFFF, 1'b0);
      send_request(32'd2, 32'hFFFF_FFFF, 1'b1);
      send_request(32'hFFFF_FFFE, 32'd0, 1'b0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_request(32'd0, 32'd1000, 1'b1);
      send_request(32'd65536, 32'd1000, 1'b0);
      send_request(32'd0, 32'd1000, 1'b0);
      send_request(32'd131072, 32'd1000, 1'b1);
      send_request(32'd131072, 32'd500, 1'b0);
      send_request(32'd131072, 32'd500, 1'b0);
      send_request(32'd196608, 32'd500, 1'b1);
      send_request(32'd196608, 32'd500, 1'b0);
      send_request(32'd65536, 32'd500, 1'b1);
      drain();
      configure(32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
      send_request(32'd1, 32'hFFFF_FFFF, 1'b0);
      send_request(32'd65536, 32'd7, 1'b1);
      drain();
      configure(32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0);
      send_request(32'd1, 32'd1, 1'b0);
      send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      drain();
   endtask

   task automatic test_config_sweep();
      logic [31:0] f_set[4] = '{32'd1, 32'hFFFF_FFFF, FORWARD_RESET, 32'h0080_0000};
      logic [31:0] t_set[4] = '{32'hFFFF_FFFF, 32'd1, 32'h0040_0000, EXPIRY_RESET};
      logic [31:0] d_set[4] = '{32'h8000_0000, 32'd1, 32'h3C00_0000, DISCOUNT_RESET};
      for (int i = 0; i < 4; i++) begin
         configure(f_set[i], t_set[i], d_set[i], (i % 2 == 0) ? 32'hFFFF_FFFF : 32'd0);
         for (int s = 0; s < 3; s++) send_strip($urandom_range(1, 4), 0);
         drain();
      end
   endtask

   task automatic test_random_strips();
      int sent;
      int len;
      for (int phase = 0; phase < 6; phase++) begin
         configure($urandom | 32'd1, ($urandom >> $urandom_range(0, 8)) | 32'd1,
                   ($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 4)) | 32'd1,
                   $urandom);
         sent = 0;
         while (sent < 105) begin
            len = $urandom_range(1, 6);
            case ($urandom_range(0, 9))
               0:       send_strip(len, 1);
               1:       send_strip(len, 2);
               default: send_strip(len, 0);
            endcase
            sent += len;
         end
         drain();
      end
   endtask

   task automatic test_input_stall();
      configure(FORWARD_RESET, EXPIRY_RESET, DISCOUNT_RESET, 32'd1);
      @(posedge clock);
      hold_rsp <= 1'b1;
      fork
         begin
            repeat (4000) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      for (int s = 0; s < 12; s++) send_strip(2, 0);
      drain();
   endtask

   initial begin
      fwd_q = FORWARD_RESET;
      tte_q = EXPIRY_RESET;
      disc_q = DISCOUNT_RESET;
      corr_q = 1'b1;
      clear_strip();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_sweep();
      test_input_stall();
      test_random_strips();
      if (error_count == 0) begin
         $display("** variance_strip_accumulator_unit: PASSED **");
      end else begin
         $display("** variance_strip_accumulator_unit: FAILED **");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/vsa_pkg.sv
design/variance_strip_accumulator_unit.sv
verif/tb_variance_strip_accumulator_unit.sv
